FILE: rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/lks_pkg.sv
// constants shared by the lru key set block
`timescale 1ns / 1ps
`default_nettype none

package lks_pkg;

    // default sizing
    localparam int unsigned DEPTH_DEF     = 16;
    localparam int unsigned KEY_WIDTH_DEF = 32;

    // fixed port widths
    localparam int unsigned CAP_W     = 5;
    localparam int unsigned FILL_W    = 5;
    localparam int unsigned IN_KEY_W  = 32;
    localparam int unsigned OUT_KEY_W = 32;

    // capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

endpackage

`default_nettype wire

FILE: rtl/lru_key_set_core.sv
// lru key set: recency list in ram, walked front to back once per word
// a word is taken only in idle; the result is registered when the walk ends on a
//   hit or at the list end, and the walk holds while a result is stalled
// one word in flight at a time: the single ram walk compares and shifts one
//   entry per cycle, unless a held result stalls it
// reset: synchronous active low; occupancy 0, capacity 16, no result held
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module lru_key_set_core #(
    parameter int unsigned DEPTH     = lks_pkg::DEPTH_DEF,
    parameter int unsigned KEY_WIDTH = lks_pkg::KEY_WIDTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [lks_pkg::CAP_W-1:0]      cfg_wr_data,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [lks_pkg::IN_KEY_W-1:0]   s_access_key,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_was_hit,
    output logic                                m_did_evict,
    output logic      [lks_pkg::OUT_KEY_W-1:0]  m_evicted_key,
    output logic      [lks_pkg::FILL_W-1:0]     m_fill_count
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned MW = (CW > lks_pkg::CAP_W) ? CW : lks_pkg::CAP_W;

    typedef enum logic {ST_IDLE, ST_SCAN} state_t;

    state_t                          state_reg, state_next;
    logic [KEY_WIDTH-1:0]            key_reg, key_next;
    logic [KEY_WIDTH-1:0]            carry_reg, carry_next;
    logic [CW-1:0]                   idx_reg, idx_next;
    logic [CW-1:0]                   occ_reg, occ_next;
    logic [lks_pkg::CAP_W-1:0]       cap_reg, cap_next;
    logic                            m_valid_reg, m_valid_next;
    logic                            hit_reg, hit_next;
    logic                            evict_reg, evict_next;
    logic [lks_pkg::OUT_KEY_W-1:0]   evkey_reg, evkey_next;
    logic [lks_pkg::FILL_W-1:0]      fill_reg, fill_next;

    logic [MW-1:0]                   cap_ext, cap_eff;
    logic                            full, out_free, at_end, key_hit;
    logic                            finish, finish_evict;
    logic [CW-1:0]                   idx_inc;

    logic                            ram_we;
    logic [AW-1:0]                   ram_waddr, ram_raddr;
    logic [KEY_WIDTH-1:0]            ram_wdata, ram_rdata;

    // recency list, entry 0 most recent
    lks_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (DEPTH)
    ) u_list (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // effective capacity, clamped to 1..DEPTH
    always_comb begin
        cap_ext = MW'(cap_reg);
        cap_eff = cap_ext;
        if (cap_ext == '0) begin
            cap_eff = MW'(1);
        end else if (cap_ext > MW'(DEPTH)) begin
            cap_eff = MW'(DEPTH);
        end
    end

    assign full     = (MW'(occ_reg) >= cap_eff) && (occ_reg != '0);
    assign out_free = !m_valid_reg || m_ready;
    assign at_end   = (idx_reg == occ_reg);
    assign key_hit  = (ram_rdata == key_reg);
    assign idx_inc  = idx_reg + CW'(1);

    assign finish       = (state_reg == ST_SCAN) && out_free && (at_end || key_hit);
    assign finish_evict = (state_reg == ST_SCAN) && out_free && at_end && full;

    // walk: write the carried key at idx, carry the old entry onwards
    always_comb begin
        state_next   = state_reg;
        key_next     = key_reg;
        carry_next   = carry_reg;
        idx_next     = idx_reg;
        occ_next     = occ_reg;
        cap_next     = cfg_wr_en ? cfg_wr_data : cap_reg;
        m_valid_next = m_valid_reg && !m_ready;
        hit_next     = hit_reg;
        evict_next   = evict_reg;
        evkey_next   = evkey_reg;
        fill_next    = fill_reg;
        ram_we       = 1'b0;
        ram_waddr    = idx_reg[AW-1:0];
        ram_wdata    = carry_reg;
        ram_raddr    = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    key_next   = KEY_WIDTH'(s_access_key);
                    carry_next = KEY_WIDTH'(s_access_key);
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!out_free) begin
                    // hold and keep the read data for idx fresh
                    ram_raddr = idx_reg[AW-1:0];
                end else if (at_end) begin
                    // miss: evict the tail or grow by one
                    ram_raddr    = idx_inc[AW-1:0];
                    m_valid_next = 1'b1;
                    hit_next     = 1'b0;
                    if (full) begin
                        evict_next = 1'b1;
                        evkey_next = lks_pkg::OUT_KEY_W'(carry_reg);
                        fill_next  = lks_pkg::FILL_W'(occ_reg);
                    end else begin
                        ram_we     = 1'b1;
                        occ_next   = occ_reg + CW'(1);
                        evict_next = 1'b0;
                        evkey_next = '0;
                        fill_next  = lks_pkg::FILL_W'(occ_reg + CW'(1));
                    end
                    state_next = ST_IDLE;
                end else begin
                    ram_raddr  = idx_inc[AW-1:0];
                    ram_we     = 1'b1;
                    carry_next = ram_rdata;
                    if (key_hit) begin
                        m_valid_next = 1'b1;
                        hit_next     = 1'b1;
                        evict_next   = 1'b0;
                        evkey_next   = '0;
                        fill_next    = lks_pkg::FILL_W'(occ_reg);
                        state_next   = ST_IDLE;
                    end else begin
                        idx_next = idx_inc;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, control and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            occ_reg     <= '0;
            cap_reg     <= lks_pkg::CAP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            cap_reg     <= cap_next;
            m_valid_reg <= m_valid_next;
        end
        key_reg   <= key_next;
        carry_reg <= carry_next;
        idx_reg   <= idx_next;
        hit_reg   <= hit_next;
        evict_reg <= evict_next;
        evkey_reg <= evkey_next;
        fill_reg  <= fill_next;
    end

    // ports
    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_was_hit     = hit_reg;
    assign m_did_evict   = evict_reg;
    assign m_evicted_key = evkey_reg;
    assign m_fill_count  = fill_reg;

    // checks
    `ASSERT_IMP(a_occ_bound, aclk, aresetn, 1'b1, occ_reg <= CW'(DEPTH))
    `ASSERT_IMP(a_idx_in_list, aclk, aresetn, state_reg == ST_SCAN, idx_reg <= occ_reg)
    `ASSERT_IMP(a_evict_keeps_occ, aclk, aresetn, finish_evict, occ_next == occ_reg)
    `ASSERT_IMP(a_hit_no_evict, aclk, aresetn, m_valid_reg, !(hit_reg && evict_reg))
    `ASSERT_NXT(a_finish_loads_out, aclk, aresetn, finish, m_valid_reg && s_ready)

endmodule

`default_nettype wire

FILE: rtl/lks_ram.sv
// simple dual-port ram, one write and one registered read per cycle
`timescale 1ns / 1ps
`default_nettype none

module lks_ram #(
    parameter int unsigned WIDTH = lks_pkg::KEY_WIDTH_DEF,
    parameter int unsigned DEPTH = lks_pkg::DEPTH_DEF,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: dv/lru_key_set_core_tb.sv
// self-checking testbench for the lru key set core
`timescale 1ns / 1ps

module lru_key_set_core_tb;

    localparam int unsigned DEPTH       = lks_pkg::DEPTH_DEF;
    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned PHASE_WORDS = 148;

    // one lookup outcome as seen on the result channel
    typedef struct packed {
        logic                          was_hit;
        logic                          did_evict;
        logic [lks_pkg::OUT_KEY_W-1:0] evicted_key;
        logic [lks_pkg::FILL_W-1:0]    fill_count;
    } lookup_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [lks_pkg::CAP_W-1:0]     cfg_wr_data = '0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [lks_pkg::IN_KEY_W-1:0]  s_access_key = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic                          m_was_hit;
    logic                          m_did_evict;
    logic [lks_pkg::OUT_KEY_W-1:0] m_evicted_key;
    logic [lks_pkg::FILL_W-1:0]    m_fill_count;

    // predictor state: keys most recent first, fill level and capacity register
    logic [lks_pkg::IN_KEY_W-1:0] lru_keys [DEPTH];
    int unsigned                  lru_fill = 0;
    logic [lks_pkg::CAP_W-1:0]    lru_capacity = lks_pkg::CAP_RESET;

    logic [lks_pkg::IN_KEY_W-1:0] key_q [$];
    logic [lks_pkg::IN_KEY_W-1:0] key_pool [$];
    lookup_t                      outcome_q [$];

    int unsigned keys_queued = 0;
    int unsigned keys_accepted = 0;
    int unsigned results_seen = 0;
    int unsigned hit_total = 0;
    int unsigned evict_total = 0;
    int unsigned cap_writes = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_gap = 0;
    int unsigned recv_gap = 0;
    logic        idle_on = 1'b1;
    logic        key_taken = 1'b0;

    lru_key_set_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_access_key  (s_access_key),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_was_hit     (m_was_hit),
        .m_did_evict   (m_did_evict),
        .m_evicted_key (m_evicted_key),
        .m_fill_count  (m_fill_count)
    );

    always #1 aclk = ~aclk;

    // capacity as the block applies it: zero reads as one, saturated at depth
    function automatic int unsigned eff_capacity(input logic [lks_pkg::CAP_W-1:0] cap);
        if (cap == 0) return 1;
        if (cap > DEPTH) return DEPTH;
        return cap;
    endfunction

    // look up one key, reorder the list and return the outcome
    function automatic lookup_t lru_access(input logic [lks_pkg::IN_KEY_W-1:0] key);
        lookup_t     res;
        int          found;
        int unsigned cap;
        res   = '0;
        found = -1;
        cap   = eff_capacity(lru_capacity);
        for (int i = 0; i < lru_fill; i++) begin
            if (found < 0 && lru_keys[i] == key) found = i;
        end
        if (found >= 0) begin
            res.was_hit = 1'b1;
            for (int i = found; i > 0; i--) lru_keys[i] = lru_keys[i-1];
            hit_total++;
        end else begin
            // full, or over a lowered capacity: drop the oldest key only
            if (lru_fill >= cap && lru_fill > 0) begin
                res.did_evict   = 1'b1;
                res.evicted_key = lru_keys[lru_fill-1];
                lru_fill--;
                evict_total++;
            end
            for (int i = lru_fill; i > 0; i--) lru_keys[i] = lru_keys[i-1];
            lru_fill++;
        end
        lru_keys[0]    = key;
        res.fill_count = lru_fill[lks_pkg::FILL_W-1:0];
        return res;
    endfunction

    task automatic flag(input string msg);
        error_count++;
        if (error_count <= 10) $display("%0t ns mismatch: %s", $realtime, msg);
    endtask

    task automatic queue_key(input logic [lks_pkg::IN_KEY_W-1:0] key);
        key_q.push_back(key);
        keys_queued++;
    endtask

    // sender holds off until every word is through and every result is back
    task automatic wait_drained(input int unsigned extra);
        while (keys_accepted != keys_queued || outcome_q.size() != 0) @(negedge aclk);
        repeat (extra) @(negedge aclk);
    endtask

    task automatic set_capacity(input logic [lks_pkg::CAP_W-1:0] cap);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(negedge aclk);
        cfg_wr_en    <= 1'b0;
        lru_capacity = cap;
        cap_writes++;
    endtask

    // mostly keys from the phase's working set, some corner values and noise
    function automatic logic [lks_pkg::IN_KEY_W-1:0] pick_key();
        int unsigned roll;
        logic [lks_pkg::IN_KEY_W-1:0] one_hot;
        roll    = $urandom_range(0, 99);
        one_hot = 32'd1 << $urandom_range(0, 31);
        if (roll < 72) return key_pool[$urandom_range(0, key_pool.size() - 1)];
        case (roll % 4)
            0: return '0;
            1: return '1;
            2: return one_hot;
            default: return $urandom;
        endcase
    endfunction

    // word driver, one payload change per falling edge
    always @(negedge aclk) begin : sender
        logic next_valid;
        next_valid = s_valid;
        if (!aresetn) begin
            next_valid = 1'b0;
        end else if (!s_valid || key_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                next_valid = 1'b0;
            end else if (key_q.size() == 0) begin
                next_valid = 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                send_gap   = $urandom_range(0, 5);
                next_valid = 1'b0;
            end else begin
                next_valid = 1'b1;
                s_access_key <= key_q.pop_front();
            end
        end
        s_valid <= next_valid;
    end

    // result side back-pressure in bursts
    always @(negedge aclk) begin : receiver
        if (recv_gap > 0) begin
            recv_gap--;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(0, 5);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor: check results, then predict for the word taken this edge
    always @(posedge aclk) begin : monitor
        lookup_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            key_taken <= aresetn && s_valid && s_ready;
            if (aresetn && m_valid && m_ready) begin
                results_seen++;
                if (outcome_q.size() == 0) begin
                    flag($sformatf("result with nothing outstanding, key %h", m_evicted_key));
                end else begin
                    want = outcome_q.pop_front();
                    if (m_was_hit !== want.was_hit)
                        flag($sformatf("was_hit exp %0d got %0d", want.was_hit, m_was_hit));
                    if (m_did_evict !== want.did_evict)
                        flag($sformatf("did_evict exp %0d got %0d", want.did_evict, m_did_evict));
                    if (m_evicted_key !== want.evicted_key)
                        flag($sformatf("evicted_key exp %h got %h",
                                       want.evicted_key, m_evicted_key));
                    if (m_fill_count !== want.fill_count)
                        flag($sformatf("fill_count exp %0d got %0d",
                                       want.fill_count, m_fill_count));
                end
            end
            if (aresetn && s_valid && s_ready) begin
                outcome_q.push_back(lru_access(s_access_key));
                keys_accepted++;
            end
        end
    end

    // stimulus sequence
    initial begin : stimulus
        logic [lks_pkg::CAP_W-1:0] phase_caps [11];
        int unsigned               pool_size;
        phase_caps = '{5'd1, 5'd16, 5'd31, 5'd0, 5'd17, 5'd3, 5'd8, 5'd12,
                       5'd0, 5'd0, 5'd0};
        for (int i = 8; i < 11; i++) phase_caps[i] = lks_pkg::CAP_W'($urandom_range(0, 31));

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // fill from empty at reset capacity, hits at the second slot, then evict
        queue_key('0);
        queue_key('1);
        queue_key('0);
        queue_key('1);
        for (int i = 0; i < 14; i++) queue_key(32'h5A5A_0000 + i);
        queue_key(32'hA5A5_A5A5);
        wait_drained(4);

        // capacity lowered under the fill level: hit keeps all, miss swaps one
        set_capacity(5'd2);
        queue_key(32'h5A5A_0005);
        queue_key('0);
        wait_drained(4);

        // zero capacity behaves as one
        set_capacity(5'd0);
        queue_key(32'h1234_5678);
        queue_key(32'h1234_5678);
        wait_drained(4);

        // capacity above depth saturates
        set_capacity(5'd31);
        queue_key(32'hFFFF_0000);
        wait_drained(4);

        // random phases over a working set sized around the capacity
        for (int p = 0; p < 11; p++) begin
            set_capacity(phase_caps[p]);
            idle_on   = (p < 9);
            pool_size = $urandom_range(1, eff_capacity(phase_caps[p]) + 3);
            key_pool.delete();
            for (int i = 0; i < pool_size; i++) begin
                key_pool.push_back(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom);
            end
            for (int i = 0; i < PHASE_WORDS; i++) queue_key(pick_key());
            wait_drained(4);
        end

        wait_drained(40);
        if (outcome_q.size() != 0) flag($sformatf("%0d results never arrived", outcome_q.size()));
        $display("sent %0d keys under %0d capacity writes, %0d results checked",
                 keys_accepted, cap_writes, results_seen);
        $display("predicted %0d hits and %0d evictions", hit_total, evict_total);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches in total", error_count);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
